>>> hdl/lptpg_pkg.sv
// Shared types, codes and lookup tables of the LED panel test pattern generator.
package lptpg_pkg;

  localparam int XW        = 10;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int PAT_W     = 4;
  localparam int CHAN_W    = 8;

  localparam int ROWID_BITS  = 9;
  localparam int TEXT_H      = 20;
  localparam int DIGIT_W     = 12;
  localparam int DIGIT_PITCH = 16;
  localparam int TEXT_W1     = DIGIT_W;
  localparam int TEXT_W2     = 2 * DIGIT_W + (DIGIT_PITCH - DIGIT_W);
  localparam int TEXT_W3     = 3 * DIGIT_W + 2 * (DIGIT_PITCH - DIGIT_W);
  localparam int L_ARM       = 8;
  localparam int SQ_OFFSET   = 4;
  localparam int SQ_SIZE     = 4;
  localparam int SQ_PITCH    = 7;
  localparam int SQ_MAX      = 8;
  localparam int BCD_W       = 12;

  typedef logic [CHAN_W-1:0] chan_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } rgb_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN = 2'd0,
    REG_WIDTH   = 2'd1,
    REG_HEIGHT  = 2'd2
  } cfg_reg_t;

  typedef enum logic [PAT_W-1:0] {
    PAT_OFF    = 4'd0,
    PAT_BARS   = 4'd1,
    PAT_GRID   = 4'd2,
    PAT_WHITE  = 4'd3,
    PAT_RED    = 4'd4,
    PAT_GREEN  = 4'd5,
    PAT_BLUE   = 4'd6,
    PAT_MAP    = 4'd7,
    PAT_ROWID  = 4'd8,
    PAT_BANDS  = 4'd9,
    PAT_CELLID = 4'd10
  } pattern_t;

  localparam rgb_t RGB_BLACK  = '{8'd0, 8'd0, 8'd0};
  localparam rgb_t RGB_WHITE  = '{8'd255, 8'd255, 8'd255};
  localparam rgb_t RGB_RED    = '{8'd255, 8'd0, 8'd0};
  localparam rgb_t RGB_GREEN  = '{8'd0, 8'd255, 8'd0};
  localparam rgb_t RGB_BLUE   = '{8'd0, 8'd0, 8'd255};
  localparam rgb_t RGB_GREY   = '{8'd64, 8'd64, 8'd64};
  localparam rgb_t RGB_BORDER = '{8'd0, 8'd200, 8'd0};

  function automatic rgb_t bar_colour(input logic [2:0] i);
    rgb_t c;
    unique case (i)
      3'd0: c = RGB_WHITE;
      3'd1: c = '{8'd255, 8'd255, 8'd0};
      3'd2: c = '{8'd0, 8'd255, 8'd255};
      3'd3: c = RGB_GREEN;
      3'd4: c = '{8'd255, 8'd0, 8'd255};
      3'd5: c = RGB_RED;
      3'd6: c = RGB_BLUE;
      default: c = RGB_BLACK;
    endcase
    return c;
  endfunction

  function automatic rgb_t cell_colour(input logic [2:0] i);
    rgb_t c;
    unique case (i)
      3'd0: c = RGB_RED;
      3'd1: c = RGB_GREEN;
      3'd2: c = RGB_BLUE;
      3'd3: c = '{8'd255, 8'd255, 8'd0};
      3'd4: c = '{8'd255, 8'd0, 8'd255};
      3'd5: c = '{8'd0, 8'd255, 8'd255};
      3'd6: c = RGB_WHITE;
      default: c = '{8'd96, 8'd96, 8'd96};
    endcase
    return c;
  endfunction

  function automatic logic [2:0] font_row(input logic [3:0] digit, input logic [2:0] row);
    logic [14:0] g;
    logic [2:0]  r;
    unique case (digit)
      4'd0: g = {3'd7, 3'd5, 3'd5, 3'd5, 3'd7};
      4'd1: g = {3'd2, 3'd6, 3'd2, 3'd2, 3'd7};
      4'd2: g = {3'd7, 3'd1, 3'd7, 3'd4, 3'd7};
      4'd3: g = {3'd7, 3'd1, 3'd7, 3'd1, 3'd7};
      4'd4: g = {3'd5, 3'd5, 3'd7, 3'd1, 3'd1};
      4'd5: g = {3'd7, 3'd4, 3'd7, 3'd1, 3'd7};
      4'd6: g = {3'd7, 3'd4, 3'd7, 3'd5, 3'd7};
      4'd7: g = {3'd7, 3'd1, 3'd1, 3'd1, 3'd1};
      4'd8: g = {3'd7, 3'd5, 3'd7, 3'd5, 3'd7};
      4'd9: g = {3'd7, 3'd5, 3'd7, 3'd1, 3'd7};
      default: g = '0;
    endcase
    unique case (row)
      3'd0: r = g[14:12];
      3'd1: r = g[11:9];
      3'd2: r = g[8:6];
      3'd3: r = g[5:3];
      3'd4: r = g[2:0];
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] div7(input logic [5:0] v);
    logic [3:0] q;
    q = '0;
    for (int k = 1; k <= 9; k++) begin
      if (v >= 6'(7 * k)) q = q + 4'd1;
    end
    return q;
  endfunction

endpackage

>>> hdl/lptpg_ifs.sv
// Pixel coordinate and colour channel interfaces.
interface lptpg_pix_if;
  import lptpg_pkg::*;
  logic          valid;
  logic          ready;
  logic [XW-1:0] pixel_x;
  logic [XW-1:0] pixel_y;
  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface lptpg_rgb_if;
  import lptpg_pkg::*;
  logic  valid;
  logic  ready;
  chan_t red;
  chan_t green;
  chan_t blue;
  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

>>> hdl/lptpg_dabble.sv
// Shift-and-add-3 binary to BCD conversion over a slice of bits, modulo 1000.
module lptpg_dabble #(
  parameter int NBITS = 6
) (
  input  logic [11:0]      bcd_in,
  input  logic [NBITS-1:0] bits,
  output logic [11:0]      bcd_out
);
  logic [11:0] b;

  always_comb begin
    b = bcd_in;
    for (int i = NBITS - 1; i >= 0; i--) begin
      for (int d = 0; d < 3; d++) begin
        if (b[4*d +: 4] >= 4'd5) b[4*d +: 4] = b[4*d +: 4] + 4'd3;
      end
      b = {b[10:0], bits[i]};
    end
    bcd_out = b;
  end
endmodule

>>> hdl/led_panel_test_pattern_generator_top.sv
// Test pattern generator: one pixel coordinate in, its RGB colour out.
// Each pixel passes through six register stages, A to F, from input transfer to output valid.
// Throughput: one pixel per cycle while out_rgb.ready is high; a stalled output holds every full stage behind it.
// The reciprocal multiplies, the cell index multiply and the split decimal conversion set the stage depth.
// Reset: synchronous, active low; clears valid bits, pattern to off, canvas to 64 x 32.
module led_panel_test_pattern_generator_top #(
  parameter int CELL_WIDTH    = 64,
  parameter int CELL_HEIGHT   = 32,
  parameter int MAX_DIMENSION = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [lptpg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lptpg_pkg::CFG_W-1:0]     cfg_data,
  lptpg_pix_if.sink                      in_pix,
  lptpg_rgb_if.source                    out_rgb
);
  import lptpg_pkg::*;

  localparam int DW     = $clog2(MAX_DIMENSION + 1);
  localparam int SW     = (DW > CFG_W) ? DW : CFG_W;
  localparam int LXW    = $clog2(CELL_WIDTH);
  localparam int LYW    = $clog2(CELL_HEIGHT);
  localparam int CYM    = ((1 << XW) - 1) / CELL_HEIGHT;
  localparam int CXW    = $clog2(((1 << XW) - 1) / CELL_WIDTH + 1);
  localparam int CYW    = $clog2(CYM + 1);
  localparam int CN_MAX = (MAX_DIMENSION / CELL_WIDTH < 1) ? 1 : MAX_DIMENSION / CELL_WIDTH;
  localparam int CNW    = $clog2(CN_MAX + 1);
  localparam int IDXW   = $clog2(CYM * CN_MAX + (1 << CXW));
  localparam int NB1    = IDXW / 2;
  localparam int NB2    = IDXW - NB1;
  localparam int RX     = (1 << XW) / CELL_WIDTH;
  localparam int RY     = (1 << XW) / CELL_HEIGHT;
  localparam int RW     = (1 << SW) / CELL_WIDTH;
  localparam int TY     = (CELL_HEIGHT - TEXT_H) / 2;
  localparam int TX1    = (CELL_WIDTH - TEXT_W1) / 2;
  localparam int TX2    = (CELL_WIDTH - TEXT_W2) / 2;
  localparam int TX3    = (CELL_WIDTH - TEXT_W3) / 2;
  localparam int BY     = CELL_HEIGHT / 2 - 2;

  // configuration
  logic [PAT_W-1:0] pattern_r;
  logic [CFG_W-1:0] width_r;
  logic [CFG_W-1:0] height_r;
  logic [SW-1:0]    w_sat;
  logic [SW-1:0]    h_sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= PAT_W'(PAT_OFF);
      width_r   <= CFG_W'(64);
      height_r  <= CFG_W'(32);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PATTERN: pattern_r <= cfg_data[PAT_W-1:0];
        REG_WIDTH:   width_r   <= cfg_data;
        REG_HEIGHT:  height_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign w_sat = (SW'(width_r) > SW'(MAX_DIMENSION)) ? SW'(MAX_DIMENSION) : SW'(width_r);
  assign h_sat = (SW'(height_r) > SW'(MAX_DIMENSION)) ? SW'(MAX_DIMENSION) : SW'(height_r);

  // stage enables
  logic a_v_r, b_v_r, c_v_r, d_v_r, e_v_r, f_v_r;
  logic en_a, en_b, en_c, en_d, en_e, en_f;

  assign en_f = !f_v_r || out_rgb.ready;
  assign en_e = !e_v_r || en_f;
  assign en_d = !d_v_r || en_e;
  assign en_c = !c_v_r || en_d;
  assign en_b = !b_v_r || en_c;
  assign en_a = !a_v_r || en_b;
  assign in_pix.ready = en_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
      e_v_r <= 1'b0;
      f_v_r <= 1'b0;
    end else begin
      if (en_a) a_v_r <= in_pix.valid;
      if (en_b) b_v_r <= a_v_r;
      if (en_c) c_v_r <= b_v_r;
      if (en_d) d_v_r <= c_v_r;
      if (en_e) e_v_r <= d_v_r;
      if (en_f) f_v_r <= e_v_r;
    end
  end

  // stage A: reciprocal multiplies
  logic [2*XW-1:0] mx, my;
  logic [2*SW-1:0] mw;
  logic [XW-1:0]   a_x_r, a_y_r;
  logic [SW-1:0]   a_w_r, a_h_r;
  logic [CXW-1:0]  a_qx_r;
  logic [CYW-1:0]  a_qy_r;
  logic [CNW-1:0]  a_qw_r;

  assign mx = (2*XW)'(in_pix.pixel_x) * (2*XW)'(RX);
  assign my = (2*XW)'(in_pix.pixel_y) * (2*XW)'(RY);
  assign mw = (2*SW)'(w_sat) * (2*SW)'(RW);

  always_ff @(posedge clk) begin
    if (en_a) begin
      a_x_r  <= in_pix.pixel_x;
      a_y_r  <= in_pix.pixel_y;
      a_w_r  <= w_sat;
      a_h_r  <= h_sat;
      a_qx_r <= CXW'(mx[2*XW-1:XW]);
      a_qy_r <= CYW'(my[2*XW-1:XW]);
      a_qw_r <= CNW'(mw[2*SW-1:SW]);
    end
  end

  // stage B: quotient correction, plain patterns
  logic [XW-1:0]  rx, ry;
  logic [SW-1:0]  rw, xr, yb;
  logic           fix_x, fix_y, fix_w;
  logic [CXW-1:0] cx_n;
  logic [CYW-1:0] cy_n;
  logic [LXW-1:0] lx_n;
  logic [LYW-1:0] ly_n;
  logic [CNW-1:0] qw, cells_n;
  logic [2:0]     bar_idx;
  logic           on_edge, on_line, m1, m2, m3;
  logic [5:0]     k1, k2, k3;
  logic [3:0]     rb;
  logic           rowid_on;
  rgb_t           grid_rgb, simple_rgb;

  always_comb begin
    rx    = a_x_r - XW'(a_qx_r * CELL_WIDTH);
    ry    = a_y_r - XW'(a_qy_r * CELL_HEIGHT);
    rw    = a_w_r - SW'(a_qw_r * CELL_WIDTH);
    fix_x = rx >= XW'(CELL_WIDTH);
    fix_y = ry >= XW'(CELL_HEIGHT);
    fix_w = rw >= SW'(CELL_WIDTH);
    cx_n  = a_qx_r + CXW'(fix_x);
    cy_n  = a_qy_r + CYW'(fix_y);
    lx_n  = fix_x ? LXW'(rx - XW'(CELL_WIDTH)) : LXW'(rx);
    ly_n  = fix_y ? LYW'(ry - XW'(CELL_HEIGHT)) : LYW'(ry);
    qw    = a_qw_r + CNW'(fix_w);
    cells_n = (qw == '0) ? CNW'(1) : qw;

    bar_idx = '0;
    for (int k = 1; k < 8; k++) begin
      if ((SW+3)'({a_x_r, 3'b000}) >= (SW+3)'(k * a_w_r)) bar_idx = bar_idx + 3'd1;
    end

    xr = a_w_r - SW'(1) - SW'(a_x_r);
    yb = a_h_r - SW'(1) - SW'(a_y_r);
    on_edge = (a_x_r == '0) || (a_y_r == '0) || (xr == '0) || (yb == '0);
    on_line = (a_x_r[2:0] == 3'd0) || (a_y_r[2:0] == 3'd0);
    m1 = (a_x_r < XW'(3)) && (a_y_r < XW'(3));
    m2 = (xr < SW'(3)) && (a_y_r < XW'(3));
    m3 = (a_x_r < XW'(3)) && (yb < SW'(3));
    k1 = {a_y_r[1:0], a_x_r[1:0], 2'b00};
    k2 = {a_y_r[1:0], xr[1:0], 2'b01};
    k3 = {yb[1:0], a_x_r[1:0], 2'b10};
    if (on_edge) grid_rgb = RGB_WHITE;
    else if (on_line) grid_rgb = RGB_GREY;
    else grid_rgb = RGB_BLACK;
    priority if (m3 && (!m2 || k3 > k2) && (!m1 || k3 > k1)) grid_rgb = RGB_BLUE;
    else if (m2 && (!m1 || k2 > k1)) grid_rgb = RGB_GREEN;
    else if (m1) grid_rgb = RGB_RED;
    else ;

    rb = div7(a_x_r[5:0]);
    rowid_on = (rb < 4'(ROWID_BITS)) && a_y_r[rb];

    unique case (pattern_r)
      PAT_OFF:   simple_rgb = RGB_BLACK;
      PAT_BARS:  simple_rgb = bar_colour(bar_idx);
      PAT_WHITE: simple_rgb = RGB_WHITE;
      PAT_RED:   simple_rgb = RGB_RED;
      PAT_GREEN: simple_rgb = RGB_GREEN;
      PAT_BLUE:  simple_rgb = RGB_BLUE;
      PAT_ROWID: simple_rgb = rowid_on ? RGB_WHITE : RGB_BLACK;
      PAT_BANDS: begin
        unique case (a_y_r[5:4])
          2'd0:    simple_rgb = RGB_RED;
          2'd1:    simple_rgb = RGB_GREEN;
          2'd2:    simple_rgb = RGB_BLUE;
          default: simple_rgb = RGB_BLACK;
        endcase
      end
      PAT_MAP, PAT_CELLID: simple_rgb = RGB_BLACK;
      default:   simple_rgb = grid_rgb;
    endcase
  end

  logic           b_inside_r, b_beyond_r;
  logic [CXW-1:0] b_cx_r;
  logic [CYW-1:0] b_cy_r;
  logic [LXW-1:0] b_lx_r;
  logic [LYW-1:0] b_ly_r;
  logic [CNW-1:0] b_cells_r;
  rgb_t           b_rgb_r;

  always_ff @(posedge clk) begin
    if (en_b) begin
      b_inside_r <= (SW'(a_x_r) < a_w_r) && (SW'(a_y_r) < a_h_r);
      b_beyond_r <= cx_n >= cells_n;
      b_cx_r     <= cx_n;
      b_cy_r     <= cy_n;
      b_lx_r     <= lx_n;
      b_ly_r     <= ly_n;
      b_cells_r  <= cells_n;
      b_rgb_r    <= simple_rgb;
    end
  end

  // stage C: cell index, cell geometry, cellid colour
  logic [LXW-1:0] sv;
  logic [3:0]     sq_q;
  logic [5:0]     sq_r;
  logic           sq_on, l_on;
  rgb_t           cell_rgb;

  always_comb begin
    sv    = b_lx_r - LXW'(SQ_OFFSET);
    sq_q  = div7(sv[5:0]);
    sq_r  = sv[5:0] - 6'(sq_q * SQ_PITCH);
    sq_on = (b_lx_r >= LXW'(SQ_OFFSET)) && (sv < LXW'(SQ_PITCH * SQ_MAX))
          && (b_ly_r >= LYW'(BY)) && (b_ly_r < LYW'(BY + SQ_SIZE))
          && (sq_r < 6'(SQ_SIZE)) && (CYW'(sq_q) <= b_cy_r || sq_q <= 4'(b_cy_r));
    l_on  = ((b_ly_r == '0) && (b_lx_r < LXW'(L_ARM)))
          || ((b_lx_r == '0) && (b_ly_r < LYW'(L_ARM)));
    cell_rgb = (sq_on || l_on) ? RGB_BLACK : cell_colour(3'(b_cx_r));
  end

  logic            c_inside_r, c_beyond_r, c_corner_r, c_border_r, c_tyhit_r;
  logic [IDXW-1:0] c_idx_r;
  logic [LXW-1:0]  c_lx_r;
  logic [4:0]      c_dy_r;
  rgb_t            c_cell_rgb_r, c_rgb_r;

  always_ff @(posedge clk) begin
    if (en_c) begin
      c_inside_r   <= b_inside_r;
      c_beyond_r   <= b_beyond_r;
      c_idx_r      <= IDXW'(b_cy_r) * IDXW'(b_cells_r) + IDXW'(b_cx_r);
      c_corner_r   <= (b_lx_r == '0) && (b_ly_r == '0);
      c_border_r   <= (b_lx_r == '0) || (b_ly_r == '0)
                   || (b_lx_r == LXW'(CELL_WIDTH - 1)) || (b_ly_r == LYW'(CELL_HEIGHT - 1));
      c_tyhit_r    <= (b_ly_r >= LYW'(TY)) && (b_ly_r < LYW'(TY + TEXT_H));
      c_dy_r       <= 5'(b_ly_r - LYW'(TY));
      c_lx_r       <= b_lx_r;
      c_cell_rgb_r <= cell_rgb;
      c_rgb_r      <= b_rgb_r;
    end
  end

  // stage D: text placement, upper half of decimal conversion
  logic [1:0]       nd;
  logic [LXW-1:0]   tx, dx;
  logic [11:0]      bcd_d;
  logic             txt_n;

  always_comb begin
    if (c_idx_r >= IDXW'(100)) begin
      nd = 2'd3;
      tx = LXW'(TX3);
    end else if (c_idx_r >= IDXW'(10)) begin
      nd = 2'd2;
      tx = LXW'(TX2);
    end else begin
      nd = 2'd1;
      tx = LXW'(TX1);
    end
    dx    = c_lx_r - tx;
    txt_n = c_tyhit_r && (c_lx_r >= tx) && (dx[LXW-1:4] < (LXW-4)'(nd))
          && (dx[3:0] < 4'(DIGIT_W));
  end

  lptpg_dabble #(.NBITS(NB1)) u_dabble_hi (
    .bcd_in  (12'd0),
    .bits    (c_idx_r[IDXW-1 -: NB1]),
    .bcd_out (bcd_d)
  );

  logic            d_inside_r, d_beyond_r, d_corner_r, d_border_r, d_txt_r;
  logic [NB2-1:0]  d_low_r;
  logic [11:0]     d_bcd_r;
  logic [1:0]      d_place_r, d_col_r;
  logic [2:0]      d_row_r;
  rgb_t            d_cell_rgb_r, d_rgb_r;

  always_ff @(posedge clk) begin
    if (en_d) begin
      d_inside_r   <= c_inside_r;
      d_beyond_r   <= c_beyond_r;
      d_corner_r   <= c_corner_r;
      d_border_r   <= c_border_r;
      d_txt_r      <= txt_n;
      d_low_r      <= c_idx_r[NB2-1:0];
      d_bcd_r      <= bcd_d;
      d_place_r    <= nd - 2'd1 - dx[5:4];
      d_col_r      <= dx[3:2];
      d_row_r      <= c_dy_r[4:2];
      d_cell_rgb_r <= c_cell_rgb_r;
      d_rgb_r      <= c_rgb_r;
    end
  end

  // stage E: lower half of decimal conversion
  logic [11:0] bcd_e;

  lptpg_dabble #(.NBITS(NB2)) u_dabble_lo (
    .bcd_in  (d_bcd_r),
    .bits    (d_low_r),
    .bcd_out (bcd_e)
  );

  logic        e_inside_r, e_beyond_r, e_corner_r, e_border_r, e_txt_r;
  logic [11:0] e_bcd_r;
  logic [1:0]  e_place_r, e_col_r;
  logic [2:0]  e_row_r;
  rgb_t        e_cell_rgb_r, e_rgb_r;

  always_ff @(posedge clk) begin
    if (en_e) begin
      e_inside_r   <= d_inside_r;
      e_beyond_r   <= d_beyond_r;
      e_corner_r   <= d_corner_r;
      e_border_r   <= d_border_r;
      e_txt_r      <= d_txt_r;
      e_bcd_r      <= bcd_e;
      e_place_r    <= d_place_r;
      e_col_r      <= d_col_r;
      e_row_r      <= d_row_r;
      e_cell_rgb_r <= d_cell_rgb_r;
      e_rgb_r      <= d_rgb_r;
    end
  end

  // stage F: glyph lookup and final selection
  logic [3:0] digit;
  logic [2:0] glyph;
  logic       glyph_on;
  rgb_t       final_rgb, f_rgb_r;

  always_comb begin
    unique case (e_place_r)
      2'd2:    digit = e_bcd_r[11:8];
      2'd1:    digit = e_bcd_r[7:4];
      default: digit = e_bcd_r[3:0];
    endcase
    glyph    = font_row(digit, e_row_r);
    glyph_on = e_txt_r && ((glyph & (3'b100 >> e_col_r)) != 3'd0);
    priority if (!e_inside_r) final_rgb = RGB_BLACK;
    else if (pattern_r == PAT_W'(PAT_MAP)) begin
      priority if (e_beyond_r) final_rgb = RGB_BLACK;
      else if (glyph_on) final_rgb = RGB_WHITE;
      else if (e_corner_r) final_rgb = RGB_RED;
      else if (e_border_r) final_rgb = RGB_BORDER;
      else final_rgb = RGB_BLACK;
    end else if (pattern_r == PAT_W'(PAT_CELLID)) begin
      final_rgb = e_beyond_r ? RGB_BLACK : e_cell_rgb_r;
    end else begin
      final_rgb = e_rgb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_f) f_rgb_r <= final_rgb;
  end

  assign out_rgb.valid = f_v_r;
  assign out_rgb.red   = f_rgb_r.red;
  assign out_rgb.green = f_rgb_r.green;
  assign out_rgb.blue  = f_rgb_r.blue;

  a_offset_in_cell: assert property (@(posedge clk) disable iff (!rst_n)
    a_v_r |-> (lx_n < LXW'(CELL_WIDTH - 1) || lx_n == LXW'(CELL_WIDTH - 1))
           && (ly_n < LYW'(CELL_HEIGHT - 1) || ly_n == LYW'(CELL_HEIGHT - 1)))
    else $error("cell offset out of range after correction");

  a_bcd_digits: assert property (@(posedge clk) disable iff (!rst_n)
    e_v_r |-> (e_bcd_r[3:0] <= 4'd9) && (e_bcd_r[7:4] <= 4'd9) && (e_bcd_r[11:8] <= 4'd9))
    else $error("decimal digit out of range");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (e_v_r && !en_e) |=> (e_v_r && $stable(e_bcd_r) && $stable(e_rgb_r)))
    else $error("stalled stage lost its item");

endmodule
